[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL modules.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fprx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package fprx_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    localparam logic [7:0] START_BYTE_RST = 8'h00;
    localparam logic [7:0] END_BYTE_RST   = 8'h00;
    localparam logic [7:0] OWN_ADDR_RST   = 8'h00;
    localparam logic [7:0] BCAST_ADDR_RST = 8'hFF;
    localparam logic       CHECK_MODE_RST = 1'b0;
    localparam logic [7:0] IDLE_LIMIT_RST = 8'hFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_CHECK   = 3'd1,
        ST_OVERRUN = 3'd2,
        ST_ADDRESS = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE = 3'd0,
        REG_END_BYTE   = 3'd1,
        REG_OWN_ADDR   = 3'd2,
        REG_BCAST_ADDR = 3'd3,
        REG_CHECK_MODE = 3'd4,
        REG_IDLE_LIMIT = 3'd5
    } reg_index_t;

    // check_mode codes
    localparam logic CHECK_SUM = 1'b0;
    localparam logic CHECK_XOR = 1'b1;

    // func codes of an input request
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_IDLE = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] own_address;
        logic [7:0] bcast_address;
        logic       check_mode;
        logic [7:0] idle_limit;
    } cfg_t;

endpackage
`default_nettype wire

[rtl/core/fprx_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_in_if
// Input channel: one received byte or idle tick per request.
// ----------------------------------------------------------------------------
interface fprx_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/fprx_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_out_if
// Result channel: status and payload bytes of received frames.
// ----------------------------------------------------------------------------
interface fprx_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output status, output payload_byte,
                    output byte_valid, output last, input ready);
    modport sink (input valid, input status, input payload_byte,
                  input byte_valid, input last, output ready);
endinterface
`default_nettype wire

[rtl/core/framed_packet_receiver_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A status result goes through the command queue, then the registered result channel.
// A good frame's payload is read out byte by byte, each through states B_READ and B_EMIT.
// Throughput: one request per cycle; input stalls from the push of a readout command
// until its payload readout ends, and on a full queue.
// Reset: configuration returns to its defaults and the receiver waits for a start byte;
// the frame store is not cleared.
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// Start/end byte deframer with address filter and sum/XOR check byte.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit #(
    parameter int STORE_DEPTH = fprx_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fprx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fprx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    fprx_in_if.sink                            in_ch,
    fprx_out_if.source                         out_ch
);
    import fprx_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CMD_W = 1 + STATUS_W + AW;

    cfg_t             cfg_reg, cfg_next;
    logic             push;
    logic [CMD_W-1:0] push_cmd;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] q_cmd;
    logic             pop;
    logic             readout_done;
    logic             st_we;
    logic [AW-1:0]    st_addr;
    logic [7:0]       st_wdata;

    // decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_START_BYTE: cfg_next.start_byte    = cfg_wdata;
                REG_END_BYTE:   cfg_next.end_byte      = cfg_wdata;
                REG_OWN_ADDR:   cfg_next.own_address   = cfg_wdata;
                REG_BCAST_ADDR: cfg_next.bcast_address = cfg_wdata;
                REG_CHECK_MODE: cfg_next.check_mode    = cfg_wdata[0];
                REG_IDLE_LIMIT: cfg_next.idle_limit    = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.end_byte      <= END_BYTE_RST;
            cfg_reg.own_address   <= OWN_ADDR_RST;
            cfg_reg.bcast_address <= BCAST_ADDR_RST;
            cfg_reg.check_mode    <= CHECK_MODE_RST;
            cfg_reg.idle_limit    <= IDLE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fprx_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_ch        (in_ch),
        .push         (push),
        .push_cmd     (push_cmd),
        .q_full       (q_full),
        .readout_done (readout_done),
        .st_we        (st_we),
        .st_addr      (st_addr),
        .st_wdata     (st_wdata)
    );

    fprx_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .data_valid (q_valid),
        .pop_data   (q_cmd)
    );

    fprx_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .st_we        (st_we),
        .st_addr      (st_addr),
        .st_wdata     (st_wdata),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .readout_done (readout_done),
        .out_ch       (out_ch)
    );
endmodule
`default_nettype wire

[rtl/core/fprx_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_queue
// Small command FIFO between the frame front end and the result back end.
// ----------------------------------------------------------------------------
module fprx_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fprx_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   data_valid,
    output logic [DATA_W-1:0]      pop_data
);
    localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [QW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QW:0]       count_reg, count_next;

    assign full       = (count_reg == (QW + 1)'(DEPTH));
    assign data_valid = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[rtl/core/fprx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fprx_front
// Frame tracker: hunts for the start byte, stores frame bytes, keeps the
// running checksum and classifies each frame end into a command.
// ----------------------------------------------------------------------------
module fprx_front #(
    parameter int STORE_DEPTH = fprx_pkg::STORE_DEPTH_DEF,
    localparam int AW = $clog2(STORE_DEPTH),
    localparam int CMD_W = 1 + fprx_pkg::STATUS_W + AW
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fprx_pkg::cfg_t   cfg,
    fprx_in_if.sink               in_ch,
    output logic                  push,
    output logic [CMD_W-1:0]      push_cmd,
    input  wire logic             q_full,
    input  wire logic             readout_done,
    output logic                  st_we,
    output logic [AW-1:0]         st_addr,
    output logic [7:0]            st_wdata
);
    import fprx_pkg::*;

    typedef struct packed {
        logic          readout;
        status_t       status;
        logic [AW-1:0] last_idx;
    } cmd_t;

    logic          collecting_reg, collecting_next;
    logic [AW-1:0] count_reg, count_next;
    logic [7:0]    idle_reg, idle_next;
    logic          pending_reg, pending_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    xor_reg, xor_next;
    logic          in_fire;
    logic [7:0]    check_val;
    cmd_t          cmd;

    // hold off input while a readout owns the store or the queue is full
    assign in_ch.ready = !q_full && !pending_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign push_cmd    = cmd;

    // checksum over all stored bytes except the last one
    assign check_val = (cfg.check_mode == CHECK_XOR) ? (xor_reg ^ last_reg)
                                                     : (sum_reg - last_reg);

    // frame state update
    always_comb
    begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        idle_next       = idle_reg;
        pending_next    = pending_reg && !readout_done;
        first_next      = first_reg;
        last_next       = last_reg;
        sum_next        = sum_reg;
        xor_next        = xor_reg;
        push            = 1'b0;
        cmd.readout     = 1'b0;
        cmd.status      = ST_OK;
        cmd.last_idx    = '0;
        st_we           = 1'b0;
        st_addr         = count_reg;
        st_wdata        = in_ch.rx_byte;

        if (in_fire)
        begin
            if (!collecting_reg)
            begin
                // wait for the start byte
                if (in_ch.func == FUNC_BYTE && in_ch.rx_byte == cfg.start_byte)
                begin
                    collecting_next = 1'b1;
                    count_next      = '0;
                    idle_next       = cfg.idle_limit;
                end
            end
            else if (in_ch.func == FUNC_IDLE)
            begin
                // count down idle ticks, abandon on expiry
                if (idle_reg <= 8'd1)
                begin
                    push            = 1'b1;
                    cmd.status      = ST_TIMEOUT;
                    collecting_next = 1'b0;
                    count_next      = '0;
                end
                else
                begin
                    idle_next = idle_reg - 8'd1;
                end
            end
            else
            begin
                idle_next = cfg.idle_limit;
                if (in_ch.rx_byte == cfg.end_byte)
                begin
                    // close the frame and classify it
                    collecting_next = 1'b0;
                    count_next      = '0;
                    push            = 1'b1;
                    if (count_reg < AW'(2))
                    begin
                        cmd.status = ST_CHECK;
                    end
                    else if (first_reg != cfg.own_address &&
                             first_reg != cfg.bcast_address)
                    begin
                        cmd.status = ST_ADDRESS;
                    end
                    else if (check_val != last_reg)
                    begin
                        cmd.status = ST_CHECK;
                    end
                    else if (count_reg == AW'(2))
                    begin
                        cmd.status = ST_OK;
                    end
                    else
                    begin
                        cmd.readout  = 1'b1;
                        cmd.last_idx = count_reg - AW'(2);
                        pending_next = 1'b1;
                    end
                end
                else
                begin
                    // store the byte and fold it into the checksums
                    st_we     = 1'b1;
                    last_next = in_ch.rx_byte;
                    if (count_reg == '0)
                    begin
                        first_next = in_ch.rx_byte;
                        sum_next   = in_ch.rx_byte;
                        xor_next   = in_ch.rx_byte;
                    end
                    else
                    begin
                        sum_next = sum_reg + in_ch.rx_byte;
                        xor_next = xor_reg ^ in_ch.rx_byte;
                    end
                    if (count_reg == AW'(STORE_DEPTH - 1))
                    begin
                        push            = 1'b1;
                        cmd.status      = ST_OVERRUN;
                        collecting_next = 1'b0;
                        count_next      = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            idle_reg       <= IDLE_LIMIT_RST;
            pending_reg    <= 1'b0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            idle_reg       <= idle_next;
            pending_reg    <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        sum_reg   <= sum_next;
        xor_reg   <= xor_next;
    end

    `ASSERT_ALWAYS(a_push_on_request, push |-> in_fire, "command pushed without a request")
    `ASSERT_ALWAYS(a_no_write_in_readout, st_we |-> !pending_reg,
        "store written while a readout is pending")
endmodule
`default_nettype wire

[rtl/core/fprx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fprx_back
// Result engine: owns the frame store, executes queued commands and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module fprx_back #(
    parameter int STORE_DEPTH = fprx_pkg::STORE_DEPTH_DEF,
    localparam int AW = $clog2(STORE_DEPTH),
    localparam int CMD_W = 1 + fprx_pkg::STATUS_W + AW
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             st_we,
    input  wire logic [AW-1:0]    st_addr,
    input  wire logic [7:0]       st_wdata,
    input  wire logic             q_valid,
    input  wire logic [CMD_W-1:0] q_cmd,
    output logic                  pop,
    output logic                  readout_done,
    fprx_out_if.source            out_ch
);
    import fprx_pkg::*;

    typedef struct packed {
        logic          readout;
        status_t       status;
        logic [AW-1:0] last_idx;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_EMIT = 3'b100
    } back_state_t;

    logic [7:0]          store_mem [STORE_DEPTH];
    logic [7:0]          rd_data_reg;
    back_state_t         state_reg, state_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [AW-1:0]       last_idx_reg, last_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [7:0]          out_payload_reg, out_payload_next;
    logic                out_bvalid_reg, out_bvalid_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;
    cmd_t                cmd;

    assign cmd      = cmd_t'(q_cmd);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.payload_byte = out_payload_reg;
    assign out_ch.byte_valid   = out_bvalid_reg;
    assign out_ch.last         = out_last_reg;

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_addr] <= st_wdata;
        end
        rd_data_reg <= store_mem[rd_addr_reg];
    end

    // command sequencer
    always_comb
    begin
        state_next       = state_reg;
        rd_addr_next     = rd_addr_reg;
        last_idx_next    = last_idx_reg;
        pop              = 1'b0;
        readout_done     = 1'b0;
        out_load         = 1'b0;
        out_status_next  = ST_OK;
        out_payload_next = 8'd0;
        out_bvalid_next  = 1'b0;
        out_last_next    = 1'b1;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (cmd.readout)
                    begin
                        pop           = 1'b1;
                        rd_addr_next  = AW'(1);
                        last_idx_next = cmd.last_idx;
                        state_next    = B_READ;
                    end
                    else if (out_free)
                    begin
                        pop             = 1'b1;
                        out_load        = 1'b1;
                        out_status_next = cmd.status;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_payload_next = rd_data_reg;
                    out_bvalid_next  = 1'b1;
                    out_last_next    = (rd_addr_reg == last_idx_reg);
                    if (rd_addr_reg == last_idx_reg)
                    begin
                        readout_done = 1'b1;
                        state_next   = B_IDLE;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                        state_next   = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_addr_reg   <= '0;
            last_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            last_idx_reg  <= last_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= out_status_next;
            out_payload_reg <= out_payload_next;
            out_bvalid_reg  <= out_bvalid_next;
            out_last_reg    <= out_last_next;
        end
    end

    `ASSERT_ALWAYS(a_rd_in_range, (state_reg != B_IDLE) |-> (rd_addr_reg <= last_idx_reg),
        "readout address passed the last payload byte")
    `ASSERT_NEXT(a_done_marks_last, readout_done, out_valid_reg && out_last_reg,
        "readout finished without a last payload result")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed packet receiver: byte and idle-tick
// requests are queued per configuration phase, a shadow deframer predicts the
// status and payload results, and a monitor compares every result in order.
// ----------------------------------------------------------------------------
module tb;
    import fprx_pkg::*;

    localparam int STORE_DEPTH = STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic       func;
        logic [7:0] rx_byte;
    } byte_request_t;

    typedef struct {
        status_t    status;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } frame_result_t;

    typedef enum int {
        FR_GOOD,
        FR_BADSUM,
        FR_BADADDR,
        FR_SHORT,
        FR_TIMEOUT,
        FR_OVERRUN,
        FR_NOISE
    } frame_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fprx_in_if in_ch ();
    fprx_out_if out_ch ();

    framed_packet_receiver_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Shadow deframer state and register copy
    cfg_t       shadow_cfg = '{START_BYTE_RST, END_BYTE_RST, OWN_ADDR_RST, BCAST_ADDR_RST,
                               CHECK_MODE_RST, IDLE_LIMIT_RST};
    logic       frame_open = 1'b0;
    logic [7:0] frame_bytes [STORE_DEPTH];
    int         stored_count = 0;
    logic [7:0] idle_left = IDLE_LIMIT_RST;

    byte_request_t pending_requests[$];
    frame_result_t expected_results[$];
    int  queued_count = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    logic in_fire = 1'b0;
    int  send_gap = 0;
    int  ready_gap = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    function automatic logic [7:0] fold_check(input logic [7:0] acc, input logic [7:0] b);
        return (shadow_cfg.check_mode == CHECK_XOR) ? (acc ^ b) : (acc + b);
    endfunction

    task automatic post_status(input status_t st);
        frame_result_t r;
        r.status = st;
        r.payload_byte = 8'h00;
        r.byte_valid = 1'b0;
        r.last = 1'b1;
        expected_results.push_back(r);
        frame_open = 1'b0;
        stored_count = 0;
    endtask

    // Judge a closed frame: length, address, check byte, then payload readout
    task automatic close_frame();
        frame_result_t r;
        logic [7:0] acc;
        acc = 8'h00;
        if (stored_count < 2)
            post_status(ST_CHECK);
        else if (frame_bytes[0] != shadow_cfg.own_address &&
                 frame_bytes[0] != shadow_cfg.bcast_address)
            post_status(ST_ADDRESS);
        else
        begin
            for (int i = 0; i + 1 < stored_count; i++)
                acc = fold_check(acc, frame_bytes[i]);
            if (acc != frame_bytes[stored_count-1])
                post_status(ST_CHECK);
            else if (stored_count == 2)
                post_status(ST_OK);
            else
            begin
                for (int i = 1; i + 1 < stored_count; i++)
                begin
                    r.status = ST_OK;
                    r.payload_byte = frame_bytes[i];
                    r.byte_valid = 1'b1;
                    r.last = (i + 2 == stored_count);
                    expected_results.push_back(r);
                end
                frame_open = 1'b0;
                stored_count = 0;
            end
        end
    endtask

    // Advance the shadow deframer by one accepted request
    task automatic absorb_request(input logic func, input logic [7:0] b);
        if (!frame_open)
        begin
            if (func == FUNC_BYTE && b == shadow_cfg.start_byte)
            begin
                frame_open = 1'b1;
                stored_count = 0;
                idle_left = shadow_cfg.idle_limit;
            end
        end
        else if (func == FUNC_IDLE)
        begin
            if (idle_left <= 8'd1)
                post_status(ST_TIMEOUT);
            else
                idle_left = idle_left - 8'd1;
        end
        else
        begin
            idle_left = shadow_cfg.idle_limit;
            if (b == shadow_cfg.end_byte)
                close_frame();
            else
            begin
                if (stored_count < STORE_DEPTH)
                    frame_bytes[stored_count] = b;
                stored_count++;
                if (stored_count >= STORE_DEPTH)
                    post_status(ST_OVERRUN);
            end
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_results.size() == 0)
            report_mismatch($sformatf("result with nothing expected: status %0d byte %02h",
                                      out_ch.status, out_ch.payload_byte));
        else
        begin
            want = expected_results.pop_front();
            if (out_ch.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          out_ch.status, want.status));
            if (out_ch.payload_byte !== want.payload_byte)
                report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                          out_ch.payload_byte, want.payload_byte));
            if (out_ch.byte_valid !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                          out_ch.byte_valid, want.byte_valid));
            if (out_ch.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, want.last));
        end
    endtask

    // Monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("framed_packet_receiver_unit: mismatch");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                absorb_request(in_ch.func, in_ch.rx_byte);
            if (out_ch.valid && out_ch.ready)
                check_result();
        end
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
    end

    // Driver: hold a request until taken, insert random gaps, then pop the next one
    always @(negedge clk)
    begin : drive_requests
        byte_request_t req;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0 && !calm && $urandom_range(0, 6) == 0)
            begin
                send_gap = $urandom_range(1, 11) - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                req = pending_requests.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= req.func;
                in_ch.rx_byte <= req.rx_byte;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result sink: stall in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            ready_gap--;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            ready_gap = $urandom_range(1, 11) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic push_byte(input logic [7:0] b);
        byte_request_t req;
        req.func = FUNC_BYTE;
        req.rx_byte = b;
        pending_requests.push_back(req);
        queued_count++;
    endtask

    task automatic push_idle();
        byte_request_t req;
        req.func = FUNC_IDLE;
        req.rx_byte = 8'($urandom_range(0, 255));
        pending_requests.push_back(req);
        queued_count++;
    endtask

    // Any byte value except the one that closes a frame
    function automatic logic [7:0] pick_data();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == shadow_cfg.end_byte);
        return b;
    endfunction

    // Idle ticks inside a frame, always short of the timeout
    task automatic push_safe_ticks();
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(0, int'(shadow_cfg.idle_limit) - 1);
            if (n > 2)
                n = 2;
            repeat (n) push_idle();
        end
    endtask

    task automatic queue_frame(input frame_kind_t kind, input int n_pay);
        logic [7:0] addr;
        logic [7:0] chk;
        logic [7:0] body[$];
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 1) == 0)
                    push_idle();
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            push_byte(shadow_cfg.start_byte);
            case (kind)
                FR_SHORT:
                begin
                    if (n_pay > 0)
                        push_byte(pick_data());
                    push_byte(shadow_cfg.end_byte);
                end
                FR_TIMEOUT:
                begin
                    repeat (n_pay) push_byte(pick_data());
                    repeat (shadow_cfg.idle_limit) push_idle();
                end
                FR_OVERRUN:
                    repeat (STORE_DEPTH) push_byte(pick_data());
                default:
                begin
                    if (kind == FR_BADADDR)
                    begin
                        do
                            addr = pick_data();
                        while (addr == shadow_cfg.own_address ||
                               addr == shadow_cfg.bcast_address);
                    end
                    else if (shadow_cfg.own_address != shadow_cfg.end_byte &&
                             (shadow_cfg.bcast_address == shadow_cfg.end_byte ||
                              $urandom_range(0, 1) == 0))
                        addr = shadow_cfg.own_address;
                    else
                        addr = shadow_cfg.bcast_address;
                    // Redraw the payload until the check byte cannot close the frame
                    do
                    begin
                        body.delete();
                        chk = addr;
                        repeat (n_pay)
                        begin
                            body.push_back(pick_data());
                            chk = fold_check(chk, body[$]);
                        end
                        if (kind == FR_BADSUM)
                            chk = chk ^ 8'($urandom_range(1, 255));
                    end
                    while (chk == shadow_cfg.end_byte);
                    push_byte(addr);
                    foreach (body[i])
                    begin
                        push_safe_ticks();
                        push_byte(body[i]);
                    end
                    push_safe_ticks();
                    push_byte(chk);
                    push_byte(shadow_cfg.end_byte);
                end
            endcase
        end
    endtask

    // Short random frames; the longest frame and the overrun are queued directly
    task automatic queue_random(input int target);
        int first;
        int pick;
        first = queued_count;
        while (queued_count - first < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                queue_frame(FR_GOOD, $urandom_range(0, 5));
            else if (pick < 14)
                queue_frame(FR_BADSUM, $urandom_range(0, 4));
            else if (pick == 14)
                queue_frame(FR_BADADDR, $urandom_range(0, 3));
            else if (pick == 15)
                queue_frame(FR_SHORT, $urandom_range(0, 1));
            else if (pick == 16)
                queue_frame(FR_TIMEOUT, $urandom_range(0, 3));
            else
                queue_frame(FR_NOISE, 0);
        end
    endtask

    // Wait until every request is taken and every result is in, then let the block settle
    task automatic wait_quiet();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // Close any frame left open so that the next register writes land on a waiting block
    task automatic end_phase();
        wait_quiet();
        if (frame_open)
        begin
            push_byte(shadow_cfg.end_byte);
            wait_quiet();
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_START_BYTE: shadow_cfg.start_byte = value;
            REG_END_BYTE:   shadow_cfg.end_byte = value;
            REG_OWN_ADDR:   shadow_cfg.own_address = value;
            REG_BCAST_ADDR: shadow_cfg.bcast_address = value;
            REG_CHECK_MODE: shadow_cfg.check_mode = value[0];
            REG_IDLE_LIMIT: shadow_cfg.idle_limit = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(input logic [7:0] start_b, input logic [7:0] end_b,
                               input logic [7:0] own, input logic [7:0] bcast,
                               input logic mode, input logic [7:0] limit);
        write_reg(REG_START_BYTE, start_b);
        write_reg(REG_END_BYTE, end_b);
        write_reg(REG_OWN_ADDR, own);
        write_reg(REG_BCAST_ADDR, bcast);
        write_reg(REG_CHECK_MODE, {7'd0, mode});
        write_reg(REG_IDLE_LIMIT, limit);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_BYTE;
        in_ch.rx_byte = 8'h00;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: start equals end, so the same byte opens and closes a frame
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        queue_frame(FR_GOOD, 2);
        end_phase();

        // Directed corners: idle limit of one, XOR check
        load_config(8'h7E, 8'h7F, 8'h00, 8'hFF, CHECK_XOR, 8'd1);
        push_byte(8'h00);
        push_idle();
        push_byte(8'h7E);
        push_idle();
        push_byte(8'h7E);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'h55);
        push_byte(8'h55);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h7F);
        end_phase();

        // Additive check: longest payload and a store overrun, then a full pause
        load_config(8'hFF, 8'h00, 8'h12, 8'hFF, CHECK_SUM, 8'd2);
        queue_frame(FR_GOOD, 29);
        queue_frame(FR_OVERRUN, 0);
        wait_quiet();
        end_phase();

        // Shared start and end byte, short idle limit
        load_config(8'hA5, 8'hA5, 8'h01, 8'h80, CHECK_XOR, 8'd4);
        queue_frame(FR_TIMEOUT, 2);
        queue_random(6);
        end_phase();

        // Final stretch without stalls on either side
        load_config(8'h00, 8'hFF, 8'hFE, 8'h00, CHECK_SUM, 8'd5);
        calm = 1'b1;
        queue_random(6);
        end_phase();
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("framed_packet_receiver_unit: match");
        else
            $display("framed_packet_receiver_unit: mismatch");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/fprx_pkg.sv
rtl/core/fprx_in_if.sv
rtl/core/fprx_out_if.sv
rtl/core/fprx_queue.sv
rtl/core/fprx_front.sv
rtl/core/fprx_back.sv
rtl/core/framed_packet_receiver_unit.sv
tb/sv/tb.sv
